// ===== rtl/core/rrc_pkg.sv =====
// ============================================================================
// rrc_pkg
// Shared types and constants of the rectangle raster canvas.
// ============================================================================
package rrc_pkg;

  // Canvas geometry
  localparam int MAX_SIDE_DEF = 256;
  localparam int SIZE_W       = 9;      // canvas size registers
  localparam int CHAR_W       = 8;
  localparam int COORD_IN_W   = 24;     // signed Q16.8 inputs
  localparam int CRD_W        = 27;     // room for corner + size and the 1.0 margin
  localparam int FRAC_W       = 8;
  localparam int ONE_Q8       = 256;

  // Configuration port
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  // Register reset values
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [CHAR_W-1:0] BG_RST     = 8'd32;

  // Shape type bytes
  localparam logic [CHAR_W-1:0] CHAR_FILLED  = 8'h52;  // 'R'
  localparam logic [CHAR_W-1:0] CHAR_OUTLINE = 8'h72;  // 'r'

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BG     = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_OUTSIDE  = 2'd2,
    STAT_RSVD     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // Result of testing one point coordinate against one axis of the rectangle
  typedef struct packed {
    logic in_span;  // lo <= p <= hi
    logic near;     // closer than 1.0 to lo or hi
  } span_t;

endpackage

// ===== rtl/core/rrc_if.sv =====
// ============================================================================
// rrc_if
// Request and response channels of the rectangle raster canvas.
// ============================================================================
interface rrc_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             operation;
  logic [rrc_pkg::CHAR_W-1:0]             shape_type;
  logic signed [rrc_pkg::COORD_IN_W-1:0]  left_x;
  logic signed [rrc_pkg::COORD_IN_W-1:0]  top_y;
  logic signed [rrc_pkg::COORD_IN_W-1:0]  rect_width;
  logic signed [rrc_pkg::COORD_IN_W-1:0]  rect_height;
  logic [rrc_pkg::CHAR_W-1:0]             paint_char;
  logic [7:0]                             read_row;
  logic [7:0]                             read_col;

  modport source (output valid, operation, shape_type, left_x, top_y, rect_width,
                  rect_height, paint_char, read_row, read_col, input ready);
  modport sink   (input valid, operation, shape_type, left_x, top_y, rect_width,
                  rect_height, paint_char, read_row, read_col, output ready);
endinterface

interface rrc_resp_if;
  logic                       valid;
  logic                       ready;
  logic [rrc_pkg::CHAR_W-1:0] cell_char;
  logic [1:0]                 status;
  logic                       error_seen;

  modport source (output valid, cell_char, status, error_seen, input ready);
  modport sink   (input valid, cell_char, status, error_seen, output ready);
endinterface

// ===== rtl/core/rectangle_raster_canvas_unit.sv =====
// ============================================================================
// rectangle_raster_canvas_unit
// Character canvas with clear, rectangle fill/outline draw and cell read.
// ============================================================================
// Usage:
//   in_req  : one request per operation (draw, clear, read), valid/ready.
//   out_rsp : exactly one response per request, in order, valid/ready.
//   APB port: canvas_width at 0x0, canvas_height at 0x4, background_char
//             at 0x8; write only while the unit is idle.
// Timing:
//   Draw and clear sweep every cell in use, one cell per cycle
//   (width, height capped at MAX_SIDE); clear writes every cell, draw
//   only the covered ones. The single write port of the canvas memory
//   sets that rate. The response is loaded in the finish state after the
//   sweep. A rejected draw, an empty canvas, a read and the unused opcode
//   skip the sweep and go from idle straight to the finish state.
//   in_req.ready is high only while no request is in work.
// Reset:
//   Synchronous, active low. Registers return to 256 x 256 with a space
//   background and the sticky error flag clears. Canvas contents are not
//   cleared; issue a clear before reading cells.
// Stall:
//   A held response does not block the next request; a finished request
//   waits in its final state until the output register frees up.
// ============================================================================
module rectangle_raster_canvas_unit #(
  parameter int MAX_SIDE = rrc_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rrc_req_if.sink                      in_req,
  rrc_resp_if.source                   out_rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrc_pkg::PADDR_W-1:0]  paddr,
  input  logic [rrc_pkg::PDATA_W-1:0]  pwdata,
  output logic [rrc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  // Derived sizes
  localparam int IW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;            // row/col index
  localparam int CW     = $clog2(MAX_SIDE + 1);                             // used size
  localparam int AW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1; // cell address
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int CMP_W  = (CW > 8) ? CW : 8;
  localparam int CRD_W  = rrc_pkg::CRD_W;
  localparam int CHAR_W = rrc_pkg::CHAR_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rrc_pkg::SIZE_W-1:0] cfg_w_r;
  logic [rrc_pkg::SIZE_W-1:0] cfg_h_r;
  logic [CHAR_W-1:0]          bg_r;
  rrc_pkg::reg_idx_t          reg_idx;
  logic                       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = rrc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= rrc_pkg::WIDTH_RST;
      cfg_h_r <= rrc_pkg::HEIGHT_RST;
      bg_r    <= rrc_pkg::BG_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        rrc_pkg::REG_WIDTH:  cfg_w_r <= pwdata[rrc_pkg::SIZE_W-1:0];
        rrc_pkg::REG_HEIGHT: cfg_h_r <= pwdata[rrc_pkg::SIZE_W-1:0];
        rrc_pkg::REG_BG:     bg_r    <= pwdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rrc_pkg::REG_WIDTH:  prdata = rrc_pkg::PDATA_W'(cfg_w_r);
      rrc_pkg::REG_HEIGHT: prdata = rrc_pkg::PDATA_W'(cfg_h_r);
      rrc_pkg::REG_BG:     prdata = rrc_pkg::PDATA_W'(bg_r);
      default:             prdata = '0;
    endcase
  end

  // Size registers above MAX_SIDE behave as MAX_SIDE
  logic [CW-1:0] w_used;
  logic [CW-1:0] h_used;

  assign w_used = (32'(cfg_w_r) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(cfg_w_r);
  assign h_used = (32'(cfg_h_r) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(cfg_h_r);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  rrc_pkg::state_t          state_r, state_nxt;
  rrc_pkg::op_t             op_r, op_nxt;
  logic                     outline_r, outline_nxt;
  logic [CHAR_W-1:0]        pc_r, pc_nxt;
  logic signed [CRD_W-1:0]  lx_r, lx_nxt, rx_r, rx_nxt;
  logic signed [CRD_W-1:0]  ty_r, ty_nxt, by_r, by_nxt;
  logic [IW-1:0]            col_r, col_nxt, row_r, row_nxt;
  logic [AW-1:0]            base_r, base_nxt;
  logic                     err_r, err_nxt;
  rrc_pkg::status_t         res_status_r, res_status_nxt;
  logic                     read_hit_r, read_hit_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]        out_cell_r, out_cell_nxt;
  rrc_pkg::status_t         out_status_r, out_status_nxt;
  logic                     out_err_r, out_err_nxt;

  // Canvas memory
  logic [CHAR_W-1:0]        mem [DEPTH];
  logic [CHAR_W-1:0]        mem_q;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [CHAR_W-1:0]        mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;

  // Compare unit, one instance per axis
  logic signed [CRD_W-1:0]  px, py;
  rrc_pkg::span_t           span_x, span_y;
  logic                     covered;

  assign px = CRD_W'({col_r, {rrc_pkg::FRAC_W{1'b0}}});
  assign py = CRD_W'({row_r, {rrc_pkg::FRAC_W{1'b0}}});

  rrc_span u_span_x (.p(px), .lo(lx_r), .hi(rx_r), .span(span_x));
  rrc_span u_span_y (.p(py), .lo(ty_r), .hi(by_r), .span(span_y));

  assign covered = span_x.in_span && span_y.in_span &&
                   (!outline_r || span_x.near || span_y.near);

  // Request decode
  rrc_pkg::op_t             in_op;
  logic                     in_acc;
  logic                     shape_ok;
  logic                     read_in;
  logic                     last_col, last_row;
  logic signed [CRD_W-1:0]  in_lx, in_ty;

  assign in_op    = rrc_pkg::op_t'(in_req.operation);
  assign in_req.ready = (state_r == rrc_pkg::ST_IDLE);
  assign in_acc   = in_req.valid && in_req.ready;
  assign shape_ok = ((in_req.shape_type == rrc_pkg::CHAR_FILLED) ||
                     (in_req.shape_type == rrc_pkg::CHAR_OUTLINE)) &&
                    (in_req.rect_width  > 0) && (in_req.rect_height > 0);
  assign read_in  = (CMP_W'(in_req.read_row) < CMP_W'(h_used)) &&
                    (CMP_W'(in_req.read_col) < CMP_W'(w_used));
  assign in_lx    = CRD_W'(in_req.left_x);
  assign in_ty    = CRD_W'(in_req.top_y);
  assign last_col = (col_r == IW'(w_used - CW'(1)));
  assign last_row = (row_r == IW'(h_used - CW'(1)));

  assign mem_re    = in_acc && (in_op == rrc_pkg::OP_READ);
  assign mem_raddr = AW'(32'(in_req.read_row) * 32'(MAX_SIDE) + 32'(in_req.read_col));
  assign mem_waddr = AW'(base_r + AW'(col_r));
  assign mem_wdata = (op_r == rrc_pkg::OP_CLEAR) ? bg_r : pc_r;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    outline_nxt    = outline_r;
    pc_nxt         = pc_r;
    lx_nxt         = lx_r;
    rx_nxt         = rx_r;
    ty_nxt         = ty_r;
    by_nxt         = by_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    base_nxt       = base_r;
    err_nxt        = err_r;
    res_status_nxt = res_status_r;
    read_hit_nxt   = read_hit_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_cell_nxt   = out_cell_r;
    out_status_nxt = out_status_r;
    out_err_nxt    = out_err_r;
    mem_we         = 1'b0;

    case (state_r)
      rrc_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_op;
          outline_nxt    = (in_req.shape_type == rrc_pkg::CHAR_OUTLINE);
          pc_nxt         = in_req.paint_char;
          lx_nxt         = in_lx;
          rx_nxt         = in_lx + CRD_W'(in_req.rect_width);
          ty_nxt         = in_ty;
          by_nxt         = in_ty + CRD_W'(in_req.rect_height);
          col_nxt        = '0;
          row_nxt        = '0;
          base_nxt       = '0;
          res_status_nxt = rrc_pkg::STAT_OK;
          read_hit_nxt   = 1'b0;
          state_nxt      = rrc_pkg::ST_FINISH;
          case (in_op)
            rrc_pkg::OP_DRAW: begin
              if (!shape_ok) begin
                err_nxt        = 1'b1;
                res_status_nxt = rrc_pkg::STAT_REJECTED;
              end else if (w_used != '0 && h_used != '0) begin
                state_nxt = rrc_pkg::ST_SWEEP;
              end
            end
            rrc_pkg::OP_CLEAR: begin
              err_nxt = 1'b0;
              if (w_used != '0 && h_used != '0) begin
                state_nxt = rrc_pkg::ST_SWEEP;
              end
            end
            rrc_pkg::OP_READ: begin
              read_hit_nxt = read_in;
              if (!read_in) begin
                res_status_nxt = rrc_pkg::STAT_OUTSIDE;
              end
            end
            default: ;
          endcase
        end
      end

      rrc_pkg::ST_SWEEP: begin
        mem_we = (op_r == rrc_pkg::OP_CLEAR) || covered;
        if (last_col) begin
          col_nxt  = '0;
          row_nxt  = row_r + IW'(1);
          base_nxt = AW'(base_r + AW'(MAX_SIDE));
          if (last_row) begin
            state_nxt = rrc_pkg::ST_FINISH;
          end
        end else begin
          col_nxt = col_r + IW'(1);
        end
      end

      rrc_pkg::ST_FINISH: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_cell_nxt   = read_hit_r ? mem_q : '0;
          out_status_nxt = res_status_r;
          out_err_nxt    = err_r;
          state_nxt      = rrc_pkg::ST_IDLE;
        end
      end

      default: state_nxt = rrc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrc_pkg::ST_IDLE;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      read_hit_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      read_hit_r  <= read_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    outline_r    <= outline_nxt;
    pc_r         <= pc_nxt;
    lx_r         <= lx_nxt;
    rx_r         <= rx_nxt;
    ty_r         <= ty_nxt;
    by_r         <= by_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    base_r       <= base_nxt;
    res_status_r <= res_status_nxt;
    out_cell_r   <= out_cell_nxt;
    out_status_r <= out_status_nxt;
    out_err_r    <= out_err_nxt;
  end

  // Canvas: one write port for the sweep, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.cell_char  = out_cell_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.error_seen = out_err_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sweep_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrc_pkg::ST_SWEEP) |->
      ((CW'(col_r) < w_used) && (CW'(row_r) < h_used)))
    else $error("sweep index outside canvas");

  a_resp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rrc_pkg::ST_FINISH))
    else $error("response loaded outside finish state");

  a_clear_resets_err: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrc_pkg::ST_FINISH && op_r == rrc_pkg::OP_CLEAR) |-> !err_r)
    else $error("error flag set after clear");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rrc_pkg::ST_SWEEP) |-> !mem_we)
    else $error("canvas write outside sweep");

  // Only a read that hits the canvas carries a cell, and it answers ok
  a_cell_zero_non_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cell_r != '0) |-> (out_status_r == rrc_pkg::STAT_OK))
    else $error("nonzero cell on failed response");

endmodule

// ===== rtl/core/rrc_span.sv =====
// ============================================================================
// rrc_span
// Compare unit: places one point coordinate against one rectangle axis.
// ============================================================================
module rrc_span (
  input  logic signed [rrc_pkg::CRD_W-1:0] p,
  input  logic signed [rrc_pkg::CRD_W-1:0] lo,
  input  logic signed [rrc_pkg::CRD_W-1:0] hi,
  output rrc_pkg::span_t                   span
);

  logic signed [rrc_pkg::CRD_W-1:0] d_lo;
  logic signed [rrc_pkg::CRD_W-1:0] d_hi;

  // Operands stay well inside CRD_W, so the differences cannot wrap
  assign d_lo = p - lo;
  assign d_hi = hi - p;

  assign span.in_span = !d_lo[rrc_pkg::CRD_W-1] && !d_hi[rrc_pkg::CRD_W-1];
  assign span.near    = (d_lo < rrc_pkg::CRD_W'(rrc_pkg::ONE_Q8)) ||
                        (d_hi < rrc_pkg::CRD_W'(rrc_pkg::ONE_Q8));

endmodule
